>>> rtl/hipt_pkg.sv
// ----------------------------------------------------------------------------
// hipt_pkg
// Shared types, codes and defaults for the hashed inverted page table.
// ----------------------------------------------------------------------------
package hipt_pkg;

  localparam int ENTRIES_DEF = 256;
  localparam int PID_W       = 12;
  localparam int PAGE_W      = 12;
  localparam int CNT_W       = 9;
  localparam int HASH_W      = 24;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_LOOKUP  = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ROOM   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page_number;
    logic [CNT_W-1:0]  page_count;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] frame_index;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       clr_wr;
    logic       idx_zero;
    logic       idx_inc;
    logic       rd;
    logic       own_chk;
    logic       page_init;
    logic       hash_direct;
    logic       hash_div;
    logic       hash_sum;
    logic       div_mod;
    logic       probe_raw;
    logic       probe_rem;
    logic       probe_adv;
    logic       alloc_wr;
    logic       rel_chk;
    logic       res_set;
    logic       res_frame;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_last;
    logic       room;
    logic       count_zero;
    logic       page_zero;
    logic       div_done;
    logic       h_over;
    logic       slot_free;
    logic       slot_match;
    logic       probe_end;
    logic       left_one;
  } sts_t;

endpackage

>>> rtl/hashed_inverted_page_table.sv
// ----------------------------------------------------------------------------
// hashed_inverted_page_table
// Inverted page table of frames with hashed linear probing.
// ----------------------------------------------------------------------------
// After reset the table is swept clear with busy high. A request is taken
// when start is high and busy low; one result beat follows with done high
// for one cycle and cannot be held off. Every table access goes through the
// single memory port; a sweep or probe reads an entry in one state and checks
// it in the next. Release sweeps every entry, lookup hashes (a divide for
// pid/page unless the page is zero, then a reciprocal reduction by ENTRIES-1
// if the hash is over ENTRIES-1) and probes, and allocate sweeps every entry
// for the ownership count, then hashes and probes per page.
module hashed_inverted_page_table #(
  parameter int ENTRIES = hipt_pkg::ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  hipt_pkg::in_t  req,
  output logic           done,
  output hipt_pkg::out_t result
);

  hipt_pkg::cmd_t cmd;
  hipt_pkg::sts_t sts;

  hipt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  hipt_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req_in (req),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule

>>> rtl/hipt_div.sv
// ----------------------------------------------------------------------------
// hipt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hipt_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hipt_pkg::HASH_W-1:0]  dividend,
  input  logic [hipt_pkg::PAGE_W-1:0]  divisor,
  output logic                         done,
  output logic [hipt_pkg::HASH_W-1:0]  quotient
);

  localparam int SW = $clog2(hipt_pkg::HASH_W);

  logic [hipt_pkg::HASH_W-1:0] q;
  logic [hipt_pkg::PAGE_W:0]   r;
  logic [hipt_pkg::PAGE_W-1:0] d;
  logic [SW-1:0]               step;
  logic                        run;
  logic [hipt_pkg::PAGE_W:0]   r_sh;
  logic [hipt_pkg::PAGE_W:0]   d_ext;

  assign r_sh  = {r[hipt_pkg::PAGE_W-1:0], q[hipt_pkg::HASH_W-1]};
  assign d_ext = {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        q    <= dividend;
        r    <= '0;
        d    <= divisor;
      end else if (run) begin
        if (r_sh >= d_ext) begin
          r <= r_sh - d_ext;
          q <= {q[hipt_pkg::HASH_W-2:0], 1'b1};
        end else begin
          r <= r_sh;
          q <= {q[hipt_pkg::HASH_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == SW'(hipt_pkg::HASH_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

>>> rtl/hipt_dp.sv
// ----------------------------------------------------------------------------
// hipt_dp
// Datapath: frame table memory, probe pointer, counters, hash and result.
// ----------------------------------------------------------------------------
module hipt_dp #(
  parameter int ENTRIES = hipt_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hipt_pkg::in_t     req_in,
  input  hipt_pkg::cmd_t    cmd,
  output hipt_pkg::sts_t    sts,
  output hipt_pkg::out_t    result
);

  localparam int IW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int CW = (FW > hipt_pkg::CNT_W) ? FW : hipt_pkg::CNT_W;
  localparam logic [IW-1:0] TOP = IW'(ENTRIES - 1);
  localparam int MD = ENTRIES - 1;
  localparam int MS = hipt_pkg::HASH_W + $clog2(MD);
  localparam logic [hipt_pkg::HASH_W:0] RECIP =
    (hipt_pkg::HASH_W + 1)'(((64'd1 << MS) + 64'(MD) - 64'd1) / 64'(MD));

  typedef struct packed {
    logic                        valid;
    logic [hipt_pkg::PID_W-1:0]  pid;
    logic [hipt_pkg::PAGE_W-1:0] page;
  } slot_t;

  slot_t mem [ENTRIES];
  slot_t rdata;
  slot_t wr_data;
  logic  wr_en;

  hipt_pkg::in_t                 req;
  logic [IW-1:0]                 idx;
  logic [IW-1:0]                 h;
  logic                          back;
  logic [FW-1:0]                 free_frames;
  logic [FW-1:0]                 owned;
  logic [hipt_pkg::CNT_W-1:0]    left;
  logic [hipt_pkg::PAGE_W-1:0]   page_cur;
  logic [hipt_pkg::PAGE_W-1:0]   page_sel;
  logic [hipt_pkg::HASH_W-1:0]   prod;
  logic [hipt_pkg::HASH_W-1:0]   h_raw;
  hipt_pkg::out_t                res;

  logic                          div_start;
  logic [hipt_pkg::HASH_W-1:0]   div_a;
  logic [hipt_pkg::PAGE_W-1:0]   div_b;
  logic                          div_done;
  logic [hipt_pkg::HASH_W-1:0]   div_q;
  logic [2*hipt_pkg::HASH_W:0]   mod_prod;
  logic [hipt_pkg::HASH_W-1:0]   mod_q;
  logic [hipt_pkg::HASH_W-1:0]   mod_r;
  logic                          pid_hit;
  logic [11:0]                   idx_ext;

  hipt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q)
  );

  assign page_sel  = (req.mode == hipt_pkg::MODE_ALLOC) ? page_cur : req.page_number;
  assign div_start = cmd.hash_div;
  assign div_a     = hipt_pkg::HASH_W'(req.pid);
  assign div_b     = page_sel;
  assign mod_prod  = h_raw * RECIP;
  assign mod_r     = h_raw - mod_q * hipt_pkg::HASH_W'(MD);
  assign pid_hit   = rdata.valid && (rdata.pid == req.pid);
  assign idx_ext   = 12'(idx);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.alloc_wr && !rdata.valid) begin
      wr_en   = 1'b1;
      wr_data = '{valid: 1'b1, pid: req.pid, page: page_cur};
    end else if (cmd.rel_chk && pid_hit) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wr_data;
    end
    if (cmd.rd) begin
      rdata <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      free_frames <= FW'(ENTRIES);
    end else begin
      if (cmd.load) begin
        req  <= req_in;
        left <= req_in.page_count;
      end
      if (cmd.idx_zero) begin
        idx   <= '0;
        owned <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.own_chk && pid_hit) begin
        owned <= owned + 1'b1;
      end
      if (cmd.page_init) begin
        page_cur <= hipt_pkg::PAGE_W'(owned);
      end
      if (cmd.hash_direct) begin
        h_raw <= hipt_pkg::HASH_W'(req.pid);
      end
      if (cmd.hash_div) begin
        prod <= hipt_pkg::HASH_W'(req.pid * page_sel);
      end
      if (cmd.hash_sum) begin
        h_raw <= prod + div_q;
      end
      if (cmd.div_mod) begin
        mod_q <= hipt_pkg::HASH_W'(mod_prod >> MS);
      end
      if (cmd.probe_raw) begin
        h    <= h_raw[IW-1:0];
        idx  <= h_raw[IW-1:0];
        back <= 1'b0;
      end
      if (cmd.probe_rem) begin
        h    <= mod_r[IW-1:0];
        idx  <= mod_r[IW-1:0];
        back <= 1'b0;
      end
      if (cmd.probe_adv) begin
        if (!back && idx == TOP) begin
          idx  <= h - 1'b1;
          back <= 1'b1;
        end else if (back) begin
          idx <= idx - 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.alloc_wr && !rdata.valid) begin
        free_frames <= free_frames - 1'b1;
        page_cur    <= page_cur + 1'b1;
        left        <= left - 1'b1;
      end
      if (cmd.rel_chk && pid_hit) begin
        free_frames <= free_frames + 1'b1;
      end
      if (cmd.res_set) begin
        res.status      <= cmd.res_status;
        res.frame_index <= cmd.res_frame ? idx_ext[7:0] : 8'd0;
      end
    end
  end

  assign sts.mode       = req.mode;
  assign sts.idx_last   = (idx == TOP);
  assign sts.room       = CW'(free_frames) >= CW'(req.page_count);
  assign sts.count_zero = (req.page_count == '0);
  assign sts.page_zero  = (page_sel == '0);
  assign sts.div_done   = div_done;
  assign sts.h_over     = (h_raw > hipt_pkg::HASH_W'(TOP));
  assign sts.slot_free  = !rdata.valid;
  assign sts.slot_match = pid_hit && (rdata.page == req.page_number);
  assign sts.probe_end  = (!back && idx == TOP && h == '0) || (back && idx == '0);
  assign sts.left_one   = (left == hipt_pkg::CNT_W'(1));
  assign result         = res;

endmodule

>>> rtl/hipt_ctrl.sv
// ----------------------------------------------------------------------------
// hipt_ctrl
// Controller: sequences clearing, counting, hashing, probing and release.
// ----------------------------------------------------------------------------
module hipt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  hipt_pkg::sts_t  sts,
  output hipt_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_OWN_RD, S_OWN_CHK, S_PAGE_INIT, S_HASH,
    S_HASH_DIV, S_HASH_MOD, S_MOD_WAIT, S_PROBE_RD, S_PROBE_CHK,
    S_REL_RD, S_REL_CHK, S_RESULT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.mode)
          hipt_pkg::MODE_ALLOC: begin
            if (!sts.room) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = hipt_pkg::ST_NO_ROOM;
              state_next     = S_RESULT;
            end else if (sts.count_zero) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = hipt_pkg::ST_OK;
              state_next     = S_RESULT;
            end else begin
              cmd.idx_zero = 1'b1;
              state_next   = S_OWN_RD;
            end
          end
          hipt_pkg::MODE_LOOKUP: state_next = S_HASH;
          hipt_pkg::MODE_RELEASE: begin
            cmd.idx_zero = 1'b1;
            state_next   = S_REL_RD;
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = hipt_pkg::ST_OK;
            state_next     = S_RESULT;
          end
        endcase
      end
      S_OWN_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_OWN_CHK;
      end
      S_OWN_CHK: begin
        cmd.own_chk = 1'b1;
        if (sts.idx_last) begin
          state_next = S_PAGE_INIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_OWN_RD;
        end
      end
      S_PAGE_INIT: begin
        cmd.page_init = 1'b1;
        state_next    = S_HASH;
      end
      S_HASH: begin
        if (sts.page_zero) begin
          cmd.hash_direct = 1'b1;
          state_next      = S_HASH_MOD;
        end else begin
          cmd.hash_div = 1'b1;
          state_next   = S_HASH_DIV;
        end
      end
      S_HASH_DIV: begin
        if (sts.div_done) begin
          cmd.hash_sum = 1'b1;
          state_next   = S_HASH_MOD;
        end
      end
      S_HASH_MOD: begin
        if (sts.h_over) begin
          cmd.div_mod = 1'b1;
          state_next  = S_MOD_WAIT;
        end else begin
          cmd.probe_raw = 1'b1;
          state_next    = S_PROBE_RD;
        end
      end
      S_MOD_WAIT: begin
        cmd.probe_rem = 1'b1;
        state_next    = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (sts.mode == hipt_pkg::MODE_ALLOC) begin
          cmd.alloc_wr = 1'b1;
          if (sts.slot_free) begin
            if (sts.left_one) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = hipt_pkg::ST_OK;
              state_next     = S_RESULT;
            end else begin
              state_next = S_HASH;
            end
          end else begin
            cmd.probe_adv = 1'b1;
            state_next    = S_PROBE_RD;
          end
        end else if (sts.slot_match) begin
          cmd.res_set    = 1'b1;
          cmd.res_frame  = 1'b1;
          cmd.res_status = hipt_pkg::ST_OK;
          state_next     = S_RESULT;
        end else if (sts.probe_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = hipt_pkg::ST_NOT_FOUND;
          state_next     = S_RESULT;
        end else begin
          cmd.probe_adv = 1'b1;
          state_next    = S_PROBE_RD;
        end
      end
      S_REL_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_REL_CHK;
      end
      S_REL_CHK: begin
        cmd.rel_chk = 1'b1;
        if (sts.idx_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = hipt_pkg::ST_OK;
          state_next     = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_REL_RD;
        end
      end
      S_RESULT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state_next == S_RESULT);
    end
  end

endmodule

>>> tb/sv/tb_hashed_inverted_page_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_inverted_page_table
// Self-checking bench for the hashed inverted page table.
// ----------------------------------------------------------------------------
// Requests are driven on the falling edge and a shadow table of frames is
// updated as each beat is taken. The expected status and frame go into a
// queue, and every done beat is compared with the oldest entry. A directed
// pass covers the empty table, a full table, refusals and the unused mode.
// Random passes then mix well-formed traffic from a small set of processes
// with noise, under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_hashed_inverted_page_table;

  localparam int NFRAMES   = hipt_pkg::ENTRIES_DEF;
  localparam int SETTLE    = 4 * NFRAMES;
  localparam longint LIMIT = 40_000_000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk, rst, start, busy, done;
  hipt_pkg::in_t  req;
  hipt_pkg::out_t result;

  hashed_inverted_page_table i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .result(result)
  );

  logic                        frame_used [NFRAMES];
  logic [hipt_pkg::PID_W-1:0]  frame_pid  [NFRAMES];
  logic [hipt_pkg::PAGE_W-1:0] frame_page [NFRAMES];
  int unsigned                 free_count;

  hipt_pkg::out_t              pending_results[$];
  int                          errors;
  int                          idle_pct;
  int                          beats_per_mode[4];
  longint                      cycles;
  logic [hipt_pkg::PID_W-1:0]  pid_pool[8];

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report("unexpected beat, status", result.status, -1);
      end else begin
        hipt_pkg::out_t want;
        want = pending_results.pop_front();
        if (result.status !== want.status) report("status", result.status, want.status);
        if (result.frame_index !== want.frame_index)
          report("frame_index", result.frame_index, want.frame_index);
      end
    end
  end

  function automatic int unsigned probe_home(input int unsigned pid, input int unsigned page);
    int unsigned h;
    h = (page != 0) ? pid * page + pid / page : pid;
    if (h > NFRAMES - 1) h = h % (NFRAMES - 1);
    return h;
  endfunction

  function automatic int unsigned probe_slot(input int unsigned h, input int unsigned k);
    return (k < NFRAMES - h) ? h + k : h - 1 - (k - (NFRAMES - h));
  endfunction

  function automatic int unsigned pages_owned(input logic [hipt_pkg::PID_W-1:0] pid);
    int unsigned n;
    n = 0;
    for (int i = 0; i < NFRAMES; i++) if (frame_used[i] && frame_pid[i] == pid) n++;
    return n;
  endfunction

  function automatic hipt_pkg::out_t apply_request(input hipt_pkg::in_t x);
    hipt_pkg::out_t r;
    int unsigned h, s, base;
    logic [hipt_pkg::PAGE_W-1:0] pg;
    r = '{status: hipt_pkg::ST_OK, frame_index: 8'd0};
    case (x.mode)
      hipt_pkg::MODE_ALLOC: begin
        if (free_count < x.page_count) begin
          r.status = hipt_pkg::ST_NO_ROOM;
        end else begin
          base = pages_owned(x.pid);
          for (int i = 0; i < x.page_count; i++) begin
            pg = hipt_pkg::PAGE_W'(base + i);
            h = probe_home(x.pid, pg);
            for (int k = 0; k < NFRAMES; k++) begin
              s = probe_slot(h, k);
              if (!frame_used[s]) begin
                frame_used[s] = 1'b1;
                frame_pid[s]  = x.pid;
                frame_page[s] = pg;
                free_count--;
                break;
              end
            end
          end
        end
      end
      hipt_pkg::MODE_LOOKUP: begin
        r.status = hipt_pkg::ST_NOT_FOUND;
        h = probe_home(x.pid, x.page_number);
        for (int k = 0; k < NFRAMES; k++) begin
          s = probe_slot(h, k);
          if (frame_used[s] && frame_pid[s] == x.pid &&
              frame_page[s] == x.page_number) begin
            r.status = hipt_pkg::ST_OK;
            r.frame_index = 8'(s);
            break;
          end
        end
      end
      hipt_pkg::MODE_RELEASE: begin
        for (int i = 0; i < NFRAMES; i++) begin
          if (frame_used[i] && frame_pid[i] == x.pid) begin
            frame_used[i] = 1'b0;
            frame_pid[i]  = '0;
            frame_page[i] = '0;
            free_count++;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input hipt_pkg::in_t x);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    req   = x;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(x));
    beats_per_mode[x.mode]++;
  endtask

  task automatic send_fields(input logic [1:0] mode, input int pid, input int page,
                             input int count);
    hipt_pkg::in_t x;
    x.mode = mode;
    x.pid = hipt_pkg::PID_W'(pid);
    x.page_number = hipt_pkg::PAGE_W'(page);
    x.page_count = hipt_pkg::CNT_W'(count);
    send_request(x);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_fields(hipt_pkg::MODE_LOOKUP, 0, 0, 0);
    send_fields(hipt_pkg::MODE_LOOKUP, 4095, 4095, 0);
    send_fields(MODE_UNUSED, 4095, 4095, 511);
    send_fields(hipt_pkg::MODE_RELEASE, 123, 0, 0);
    send_fields(hipt_pkg::MODE_ALLOC, 4095, 0, 0);
  endtask

  task automatic test_small_alloc();
    send_fields(hipt_pkg::MODE_ALLOC, 0, 0, 3);
    for (int p = 0; p < 4; p++) send_fields(hipt_pkg::MODE_LOOKUP, 0, p, 0);
    send_fields(hipt_pkg::MODE_ALLOC, 4095, 0, 2);
    send_fields(hipt_pkg::MODE_LOOKUP, 4095, 1, 0);
    send_fields(hipt_pkg::MODE_ALLOC, 1, 0, 256);
    send_fields(hipt_pkg::MODE_ALLOC, 1, 0, 511);
    send_fields(hipt_pkg::MODE_RELEASE, 0, 0, 0);
    send_fields(hipt_pkg::MODE_RELEASE, 4095, 0, 0);
  endtask

  task automatic test_full_table();
    send_fields(hipt_pkg::MODE_ALLOC, 7, 0, 256);
    send_fields(hipt_pkg::MODE_LOOKUP, 7, 255, 0);
    send_fields(hipt_pkg::MODE_LOOKUP, 7, 256, 0);
    send_fields(hipt_pkg::MODE_LOOKUP, 8, 0, 0);
    send_fields(hipt_pkg::MODE_ALLOC, 9, 0, 1);
    send_fields(hipt_pkg::MODE_ALLOC, 9, 0, 0);
    send_fields(hipt_pkg::MODE_RELEASE, 7, 0, 0);
    send_fields(hipt_pkg::MODE_RELEASE, 7, 0, 0);
    drain_results();
  endtask

  task automatic send_random_request();
    hipt_pkg::in_t x;
    int  r, n;
    r = $urandom_range(99);
    x.pid = pid_pool[$urandom_range(7)];
    x.page_number = hipt_pkg::PAGE_W'($urandom());
    x.page_count  = hipt_pkg::CNT_W'($urandom());
    if (r < 10) begin
      x.mode = 2'($urandom_range(3));
    end else if (r < 18 || free_count < 24) begin
      x.mode = hipt_pkg::MODE_RELEASE;
    end else if (r < 60) begin
      x.mode = hipt_pkg::MODE_ALLOC;
      x.page_count = ($urandom_range(49) == 0) ? hipt_pkg::CNT_W'($urandom_range(511))
                                                : hipt_pkg::CNT_W'($urandom_range(6));
    end else begin
      x.mode = hipt_pkg::MODE_LOOKUP;
      n = pages_owned(x.pid);
      x.page_number = hipt_pkg::PAGE_W'($urandom_range(n + 1));
    end
    send_request(x);
  endtask

  task automatic test_random_traffic(input int pct, input int count);
    idle_pct = pct;
    for (int i = 0; i < 8; i++) pid_pool[i] = hipt_pkg::PID_W'($urandom());
    pid_pool[0] = '0;
    for (int i = 0; i < count; i++) send_random_request();
    drain_results();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    start = 1'b0;
    req = '0;
    free_count = NFRAMES;
    for (int i = 0; i < NFRAMES; i++) begin
      frame_used[i] = 1'b0;
      frame_pid[i]  = '0;
      frame_page[i] = '0;
    end
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_small_alloc();
    test_full_table();
    test_random_traffic(0, 260);
    test_random_traffic(59, 260);
    test_random_traffic(0, 260);
    test_random_traffic(30, 260);

    $display("covered %0d allocate, %0d lookup, %0d release, %0d unused-mode beats",
             beats_per_mode[0], beats_per_mode[1], beats_per_mode[2], beats_per_mode[3]);
    $display("in %0d cycles, with %0d mismatches", cycles, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
